// ===== design/fdct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdct_pkg: shared types, widths and tables of the 8x8 forward DCT
// Fixed-point formats, the cosine table, sequencer states and the control
// and status bundles passed between the sequencer and the MAC datapath.
// ----------------------------------------------------------------------------
package fdct_pkg;

	localparam int BLOCK_SAMPLES  = 64;
	localparam int COS_FRAC_BITS  = 14;
	localparam int ROW_FRAC_BITS  = 3;
	localparam int ROW_LEN        = 8;
	localparam int LEVEL_SHIFT    = 128;

	localparam int ADDR_W  = $clog2(BLOCK_SAMPLES);
	localparam int IDX_W   = $clog2(ROW_LEN);
	localparam int TERM_W  = IDX_W - 1;
	localparam int SAMPLE_W = 8;
	localparam int SMP_W   = 9;
	localparam int ROW_W   = 16;
	localparam int COEF_W  = 12;
	localparam int COS_W   = COS_FRAC_BITS + 2;
	localparam int BFLY_W  = ROW_W + 1;
	localparam int ACC_W   = BFLY_W + COS_W + 1;
	localparam int PROD_W  = ACC_W + COS_W;

	localparam int ROW_SHIFT  = COS_FRAC_BITS - ROW_FRAC_BITS;
	localparam int COEF_SHIFT = ROW_FRAC_BITS + 2 * COS_FRAC_BITS;
	localparam int ROW_MAX    = (2 ** (ROW_W - 1)) - 1;
	localparam int ROW_MIN    = -(2 ** (ROW_W - 1));
	localparam int COEF_MAX   = (2 ** (COEF_W - 1)) - 1;
	localparam int COEF_MIN   = -(2 ** (COEF_W - 1));

	localparam logic [IDX_W-1:0]  ROW_LAST  = IDX_W'(ROW_LEN - 1);
	localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(ROW_LEN / 2 - 1);

	// cos(m*pi/16) for m = 0..8 with 30 fraction bits
	localparam logic [31:0] COS_Q30 [9] = '{
		32'd1073741824, 32'd1053110176, 32'd992008094, 32'd892783698,
		32'd759250125, 32'd596538995, 32'd410903207, 32'd209476638, 32'd0
	};

	typedef enum logic [1:0] {
		OP_ROW_MAC,
		OP_COL_MAC,
		OP_SCALE
	} fdct_op_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ROW_MAC,
		ST_ROW_DRAIN,
		ST_ROW_WR,
		ST_COL_MAC,
		ST_COL_DRAIN,
		ST_SCALE,
		ST_SCALE_DRAIN,
		ST_EMIT
	} fdct_state_t;

	typedef struct packed {
		logic                    valid;
		fdct_op_t                op;
		logic                    first;
		logic                    odd;
		logic signed [COS_W-1:0] coef;
	} fdct_tag_t;

	typedef struct packed {
		fdct_tag_t         tag;
		logic [ADDR_W-1:0] rd_addr0;
		logic [ADDR_W-1:0] rd_addr1;
		logic              smp_we;
		logic [ADDR_W-1:0] smp_waddr;
		logic              row_we;
		logic [ADDR_W-1:0] row_waddr;
		logic              out_load;
		logic              out_last;
		logic              in_ready;
	} fdct_ctl_t;

	typedef struct packed {
		logic                     busy;
		logic signed [ROW_W-1:0]  row_res;
		logic signed [COEF_W-1:0] coef_res;
	} fdct_stat_t;

	// round(cos(m*pi/16) * 2^F), signed, m taken modulo 32
	function automatic logic signed [COS_W-1:0] cos_fixed(input logic [4:0] m);
		logic [3:0]  idx;
		logic        neg;
		logic [31:0] mag;
		neg = 1'b0;
		if (m <= 5'd8) begin
			idx = 4'(m);
		end else if (m <= 5'd16) begin
			idx = 4'(5'd16 - m);
			neg = 1'b1;
		end else if (m <= 5'd24) begin
			idx = 4'(m - 5'd16);
			neg = 1'b1;
		end else begin
			idx = 4'(6'd32 - {1'b0, m});
		end
		mag = (COS_Q30[idx] + (32'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
		return neg ? -COS_W'(mag) : COS_W'(mag);
	endfunction

	// c(v)c(u)/4 in units of 2^-F
	function automatic logic signed [COS_W-1:0] scale_fixed(
		input logic [IDX_W-1:0] v,
		input logic [IDX_W-1:0] u
	);
		logic [31:0] half_root;
		half_root = (COS_Q30[4] + (32'd1 << (31 - COS_FRAC_BITS))) >> (32 - COS_FRAC_BITS);
		if (v == '0 && u == '0) begin
			return COS_W'(1) << (COS_FRAC_BITS - 3);
		end else if (v == '0 || u == '0) begin
			return COS_W'(half_root);
		end
		return COS_W'(1) << (COS_FRAC_BITS - 2);
	endfunction

endpackage
`default_nettype wire

// ===== design/fdct_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdct_ram: generic RAM, one write port and two registered read ports
// ----------------------------------------------------------------------------
module fdct_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output logic      [WIDTH-1:0]         rdata0,
	output logic      [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule
`default_nettype wire

// ===== design/fdct_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdct_mac: shared butterfly / multiply / accumulate datapath
// Three stages behind the RAM read: butterfly into operand registers, one
// multiplier, accumulator. Rounds and saturates row and output results.
// ----------------------------------------------------------------------------
module fdct_mac (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire fdct_pkg::fdct_tag_t                 tag,
	input  wire logic [fdct_pkg::SMP_W-1:0]          smp_rd0,
	input  wire logic [fdct_pkg::SMP_W-1:0]          smp_rd1,
	input  wire logic [fdct_pkg::ROW_W-1:0]          row_rd0,
	input  wire logic [fdct_pkg::ROW_W-1:0]          row_rd1,
	output fdct_pkg::fdct_stat_t                     stat
);

	logic v_s1, v_s2, v_s3;
	fdct_pkg::fdct_op_t op_s1, op_s2, op_s3;
	logic first_s1, first_s2, first_s3;
	logic odd_s1;
	logic signed [fdct_pkg::COS_W-1:0]  coef_s1, mul_b_s2;
	logic signed [fdct_pkg::ACC_W-1:0]  mul_a_s2, acc_q;
	logic signed [fdct_pkg::PROD_W-1:0] prod_s3;
	logic signed [fdct_pkg::BFLY_W-1:0] x0, x1, bfly;
	logic signed [fdct_pkg::ACC_W:0]    row_sum, row_shr;
	logic signed [fdct_pkg::PROD_W:0]   coef_sum, coef_shr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= tag.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// pick the store for this phase, then add or subtract the mirrored pair
	always_comb begin
		if (op_s1 == fdct_pkg::OP_ROW_MAC) begin
			x0 = fdct_pkg::BFLY_W'($signed(smp_rd0));
			x1 = fdct_pkg::BFLY_W'($signed(smp_rd1));
		end else begin
			x0 = fdct_pkg::BFLY_W'($signed(row_rd0));
			x1 = fdct_pkg::BFLY_W'($signed(row_rd1));
		end
		bfly = odd_s1 ? x0 - x1 : x0 + x1;
	end

	always_ff @(posedge clk) begin
		if (tag.valid) begin
			op_s1    <= tag.op;
			first_s1 <= tag.first;
			odd_s1   <= tag.odd;
			coef_s1  <= tag.coef;
		end
		if (v_s1) begin
			mul_a_s2 <= (op_s1 == fdct_pkg::OP_SCALE) ? acc_q : fdct_pkg::ACC_W'(bfly);
			mul_b_s2 <= coef_s1;
			op_s2    <= op_s1;
			first_s2 <= first_s1;
		end
		if (v_s2) begin
			prod_s3  <= fdct_pkg::PROD_W'(mul_a_s2) * fdct_pkg::PROD_W'(mul_b_s2);
			op_s3    <= op_s2;
			first_s3 <= first_s2;
		end
		if (v_s3 && op_s3 != fdct_pkg::OP_SCALE) begin
			acc_q <= (first_s3 ? '0 : acc_q) + $signed(prod_s3[fdct_pkg::ACC_W-1:0]);
		end
	end

	// round half up, then saturate
	always_comb begin
		row_sum = $signed({acc_q[fdct_pkg::ACC_W-1], acc_q})
			+ $signed((fdct_pkg::ACC_W + 1)'(1) << (fdct_pkg::ROW_SHIFT - 1));
		row_shr = row_sum >>> fdct_pkg::ROW_SHIFT;
		if (row_shr > (fdct_pkg::ACC_W + 1)'(fdct_pkg::ROW_MAX)) begin
			stat.row_res = fdct_pkg::ROW_W'(fdct_pkg::ROW_MAX);
		end else if (row_shr < (fdct_pkg::ACC_W + 1)'(fdct_pkg::ROW_MIN)) begin
			stat.row_res = fdct_pkg::ROW_W'(fdct_pkg::ROW_MIN);
		end else begin
			stat.row_res = row_shr[fdct_pkg::ROW_W-1:0];
		end

		coef_sum = $signed({prod_s3[fdct_pkg::PROD_W-1], prod_s3})
			+ $signed((fdct_pkg::PROD_W + 1)'(1) << (fdct_pkg::COEF_SHIFT - 1));
		coef_shr = coef_sum >>> fdct_pkg::COEF_SHIFT;
		if (coef_shr > (fdct_pkg::PROD_W + 1)'(fdct_pkg::COEF_MAX)) begin
			stat.coef_res = fdct_pkg::COEF_W'(fdct_pkg::COEF_MAX);
		end else if (coef_shr < (fdct_pkg::PROD_W + 1)'(fdct_pkg::COEF_MIN)) begin
			stat.coef_res = fdct_pkg::COEF_W'(fdct_pkg::COEF_MIN);
		end else begin
			stat.coef_res = coef_shr[fdct_pkg::COEF_W-1:0];
		end

		stat.busy = v_s1 | v_s2 | v_s3;
	end

endmodule
`default_nettype wire

// ===== design/fdct_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdct_seq: sequencer of the 8x8 forward DCT
// Counts samples, issues the row and column multiply-accumulate terms and the
// scaling products, waits for the datapath to drain, and schedules row writes and output beats.
// ----------------------------------------------------------------------------
module fdct_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	input  wire logic                 out_free,
	input  wire fdct_pkg::fdct_stat_t stat,
	output fdct_pkg::fdct_ctl_t       ctl
);

	fdct_pkg::fdct_state_t state_q, state_d;
	logic [fdct_pkg::ADDR_W-1:0] cnt_q;
	logic [fdct_pkg::IDX_W-1:0]  row_q, k_q, u_q;
	logic [fdct_pkg::TERM_W-1:0] n_q;
	logic                        accept;
	logic [4:0]                  cos_m;

	// angle index k*(2n+1) modulo 32
	assign cos_m = 5'({2'b00, k_q} * {2'b00, n_q, 1'b1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdct_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		accept  = 1'b0;
		unique case (state_q)
			fdct_pkg::ST_LOAD: begin
				ctl.in_ready  = 1'b1;
				ctl.smp_we    = sample_valid;
				ctl.smp_waddr = cnt_q;
				if (sample_valid) begin
					accept = 1'b1;
					if (cnt_q[fdct_pkg::IDX_W-1:0] == fdct_pkg::ROW_LAST) begin
						state_d = fdct_pkg::ST_ROW_MAC;
					end
				end
			end
			fdct_pkg::ST_ROW_MAC: begin
				ctl.tag.valid = 1'b1;
				ctl.tag.op    = fdct_pkg::OP_ROW_MAC;
				ctl.tag.first = (n_q == '0);
				ctl.tag.odd   = k_q[0];
				ctl.tag.coef  = fdct_pkg::cos_fixed(cos_m);
				ctl.rd_addr0  = {row_q, 1'b0, n_q};
				ctl.rd_addr1  = {row_q, 1'b1, ~n_q};
				if (n_q == fdct_pkg::TERM_LAST) begin
					state_d = fdct_pkg::ST_ROW_DRAIN;
				end
			end
			fdct_pkg::ST_ROW_DRAIN: begin
				if (!stat.busy) begin
					state_d = fdct_pkg::ST_ROW_WR;
				end
			end
			fdct_pkg::ST_ROW_WR: begin
				ctl.row_we    = 1'b1;
				ctl.row_waddr = {row_q, k_q};
				if (k_q == fdct_pkg::ROW_LAST) begin
					state_d = (row_q == fdct_pkg::ROW_LAST) ? fdct_pkg::ST_COL_MAC
						: fdct_pkg::ST_LOAD;
				end else begin
					state_d = fdct_pkg::ST_ROW_MAC;
				end
			end
			fdct_pkg::ST_COL_MAC: begin
				ctl.tag.valid = 1'b1;
				ctl.tag.op    = fdct_pkg::OP_COL_MAC;
				ctl.tag.first = (n_q == '0);
				ctl.tag.odd   = k_q[0];
				ctl.tag.coef  = fdct_pkg::cos_fixed(cos_m);
				ctl.rd_addr0  = {1'b0, n_q, u_q};
				ctl.rd_addr1  = {1'b1, ~n_q, u_q};
				if (n_q == fdct_pkg::TERM_LAST) begin
					state_d = fdct_pkg::ST_COL_DRAIN;
				end
			end
			fdct_pkg::ST_COL_DRAIN: begin
				if (!stat.busy) begin
					state_d = fdct_pkg::ST_SCALE;
				end
			end
			fdct_pkg::ST_SCALE: begin
				ctl.tag.valid = 1'b1;
				ctl.tag.op    = fdct_pkg::OP_SCALE;
				ctl.tag.coef  = fdct_pkg::scale_fixed(k_q, u_q);
				state_d       = fdct_pkg::ST_SCALE_DRAIN;
			end
			fdct_pkg::ST_SCALE_DRAIN: begin
				if (!stat.busy) begin
					state_d = fdct_pkg::ST_EMIT;
				end
			end
			fdct_pkg::ST_EMIT: begin
				ctl.out_load = out_free;
				ctl.out_last = (k_q == fdct_pkg::ROW_LAST) && (u_q == fdct_pkg::ROW_LAST);
				if (out_free) begin
					state_d = ctl.out_last ? fdct_pkg::ST_LOAD : fdct_pkg::ST_COL_MAC;
				end
			end
			default: begin
				state_d = fdct_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			row_q <= '0;
			k_q   <= '0;
			u_q   <= '0;
			n_q   <= '0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_q + 1'b1;
				row_q <= cnt_q[fdct_pkg::ADDR_W-1:fdct_pkg::IDX_W];
			end
			if (state_q == fdct_pkg::ST_ROW_MAC || state_q == fdct_pkg::ST_COL_MAC) begin
				n_q <= n_q + 1'b1;
			end
			if (state_q == fdct_pkg::ST_ROW_WR) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == fdct_pkg::ST_EMIT && out_free) begin
				u_q <= u_q + 1'b1;
				if (u_q == fdct_pkg::ROW_LAST) begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !stat.busy)
		else $error("sample taken while datapath busy");

	a_row_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.row_we |-> !stat.busy)
		else $error("row write before accumulator settled");

	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !stat.busy)
		else $error("output loaded before scale product settled");

	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cnt_q[fdct_pkg::IDX_W-1:0] == fdct_pkg::ROW_LAST
		|=> state_q == fdct_pkg::ST_ROW_MAC)
		else $error("row transform not started after eighth sample");

	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load && ctl.out_last |-> cnt_q == '0)
		else $error("block ended with sample count not wrapped");
`endif

endmodule
`default_nettype wire

// ===== design/forward_dct_8x8.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// forward_dct_8x8: 8x8 forward DCT of one pixel block, fixed point
// Takes 64 pixel samples in row order and returns 64 rounded, saturated DCT
// coefficients in row-major frequency order, the last one flagged.
// ----------------------------------------------------------------------------
// Usage: feed the 64 samples of a block, row by row, on the sample channel.
// Each sample is taken while sample_stall is low. After every eighth sample
// the block computes that row's 1D transform and holds sample_stall high
// through it: for each of 8 frequencies, 4 multiply-accumulates, a drain of
// the datapath and a write to the row store. After the 64th sample it runs
// the column transforms and the c(u)c(v)/4 scaling, one coefficient after
// another. The single shared multiplier does every butterfly product and
// every scaling product in turn. Each coefficient goes out on the result
// channel as soon as it is ready; a stalled result beat holds the sequencer
// at the next coefficient until that beat is taken. The next block's samples
// are accepted right after the beat marked last is loaded, even while that
// beat still waits to be taken.
// ----------------------------------------------------------------------------
module forward_dct_8x8 (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 sample_valid,
	output logic                                      sample_stall,
	input  wire logic [fdct_pkg::SAMPLE_W-1:0]        sample,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic signed [fdct_pkg::COEF_W-1:0]        coefficient,
	output logic                                      last
);

	fdct_pkg::fdct_ctl_t  ctl;
	fdct_pkg::fdct_stat_t stat;

	logic [fdct_pkg::SMP_W-1:0] smp_wdata;
	logic [fdct_pkg::SMP_W-1:0] smp_rd0, smp_rd1;
	logic [fdct_pkg::ROW_W-1:0] row_rd0, row_rd1;
	logic                       out_free;

	logic                              out_valid_q;
	logic signed [fdct_pkg::COEF_W-1:0] coef_q;
	logic                              last_q;

	// level shift: store sample - 128 as a signed 9-bit value
	assign smp_wdata = fdct_pkg::SMP_W'({1'b0, sample})
		- fdct_pkg::SMP_W'(fdct_pkg::LEVEL_SHIFT);

	// the output register can take a new coefficient when empty or draining
	assign out_free = !out_valid_q || !result_stall;

	// hold off samples whenever the sequencer is busy with a transform
	assign sample_stall = !ctl.in_ready;

	fdct_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.out_free     (out_free),
		.stat         (stat),
		.ctl          (ctl)
	);

	// level-shifted samples of the current block
	fdct_ram #(
		.WIDTH (fdct_pkg::SMP_W),
		.DEPTH (fdct_pkg::BLOCK_SAMPLES)
	) u_smp_ram (
		.clk    (clk),
		.we     (ctl.smp_we),
		.waddr  (ctl.smp_waddr),
		.wdata  (smp_wdata),
		.raddr0 (ctl.rd_addr0),
		.raddr1 (ctl.rd_addr1),
		.rdata0 (smp_rd0),
		.rdata1 (smp_rd1)
	);

	// row transform results, 3 fraction bits
	fdct_ram #(
		.WIDTH (fdct_pkg::ROW_W),
		.DEPTH (fdct_pkg::BLOCK_SAMPLES)
	) u_row_ram (
		.clk    (clk),
		.we     (ctl.row_we),
		.waddr  (ctl.row_waddr),
		.wdata  (stat.row_res),
		.raddr0 (ctl.rd_addr0),
		.raddr1 (ctl.rd_addr1),
		.rdata0 (row_rd0),
		.rdata1 (row_rd1)
	);

	fdct_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag     (ctl.tag),
		.smp_rd0 (smp_rd0),
		.smp_rd1 (smp_rd1),
		.row_rd0 (row_rd0),
		.row_rd1 (row_rd1),
		.stat    (stat)
	);

	// output register: load a finished coefficient, drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			coef_q <= stat.coef_res;
			last_q <= ctl.out_last;
		end
	end

	assign result_valid = out_valid_q;
	assign coefficient  = coef_q;
	assign last         = last_q;

endmodule
`default_nettype wire
